>>> hdl/stt_pkg.sv
package stt_pkg;

  // sizing of the tag stores
  localparam int unsigned MEM_WORDS   = 65536;
  localparam int unsigned MEM_AW      = $clog2(MEM_WORDS);
  localparam int unsigned TAG_BITS    = 16;
  localparam int unsigned NUM_REGS    = 32;
  localparam int unsigned REG_AW      = $clog2(NUM_REGS);
  // low bits of rs1 + imm that reach the doubleword index
  localparam int unsigned SUM_W       = MEM_AW + 3;
  // decoupling queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef logic [TAG_BITS-1:0] tag_t;
  typedef logic [MEM_AW-1:0]   mem_idx_t;
  typedef logic [REG_AW-1:0]   reg_idx_t;

  // instruction function codes
  typedef enum logic [3:0] {
    FN_ADDI   = 4'd0,
    FN_LD     = 4'd1,
    FN_SD     = 4'd2,
    FN_ADD    = 4'd3,
    FN_SUB    = 4'd4,
    FN_MUL    = 4'd5,
    FN_DIVU   = 4'd6,
    FN_REMU   = 4'd7,
    FN_SLTU   = 4'd8,
    FN_BEQ    = 4'd9,
    FN_JAL    = 4'd10,
    FN_JALR   = 4'd11,
    FN_LUI    = 4'd12,
    FN_OTHER  = 4'd13,
    FN_SETTAG = 4'd14
  } func_e;

  // what the back end does with an instruction
  typedef enum logic [2:0] {
    CLS_NONE,
    CLS_ADDI,
    CLS_LOAD,
    CLS_STORE,
    CLS_ALU,
    CLS_BRANCH,
    CLS_CONCRETE,
    CLS_SETTAG
  } cls_e;

  // back end sequencer
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  // one classified instruction held in the queue
  typedef struct packed {
    cls_e        cls;
    logic [3:0]  func;
    reg_idx_t    rd;
    reg_idx_t    rs1;
    reg_idx_t    rs2;
    logic [63:0] v1;
    logic [63:0] v2;
    logic [11:0] imm;
    tag_t        seed;
    mem_idx_t    mem_idx;
  } item_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  // back end to front end control
  typedef struct packed {
    logic pop;
    logic clearing;
  } back_ctl_t;

  function automatic cls_e classify(input logic [3:0] fn);
    cls_e c;
    c = CLS_NONE;
    case (fn)
      FN_ADDI:   c = CLS_ADDI;
      FN_LD:     c = CLS_LOAD;
      FN_SD:     c = CLS_STORE;
      FN_ADD:    c = CLS_ALU;
      FN_SUB:    c = CLS_ALU;
      FN_MUL:    c = CLS_ALU;
      FN_DIVU:   c = CLS_ALU;
      FN_REMU:   c = CLS_ALU;
      FN_SLTU:   c = CLS_ALU;
      FN_BEQ:    c = CLS_BRANCH;
      FN_JAL:    c = CLS_CONCRETE;
      FN_JALR:   c = CLS_CONCRETE;
      FN_LUI:    c = CLS_CONCRETE;
      FN_SETTAG: c = CLS_SETTAG;
      default:   c = CLS_NONE;
    endcase
    return c;
  endfunction

endpackage

>>> hdl/stt_front.sv
module stt_front import stt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  func_i,
  input  logic [4:0]  dest_reg_i,
  input  logic [4:0]  src1_reg_i,
  input  logic [4:0]  src2_reg_i,
  input  logic [63:0] src1_value_i,
  input  logic [63:0] src2_value_i,
  input  logic [11:0] immediate_i,
  input  logic [15:0] seed_tag_i,
  input  back_ctl_t   ctl_i,
  output head_t       head_o
);

  item_t             queue_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   count_q, count_d;
  logic              push;
  logic              pop;
  item_t             new_item;
  logic [SUM_W-1:0]  addr_sum;

  // doubleword index from the low bits of rs1 + imm
  assign addr_sum = src1_value_i[SUM_W-1:0] + SUM_W'($signed(immediate_i));

  // classify the incoming instruction
  always_comb begin
    new_item.cls     = classify(func_i);
    new_item.func    = func_i;
    new_item.rd      = reg_idx_t'(dest_reg_i);
    new_item.rs1     = reg_idx_t'(src1_reg_i);
    new_item.rs2     = reg_idx_t'(src2_reg_i);
    new_item.v1      = src1_value_i;
    new_item.v2      = src2_value_i;
    new_item.imm     = immediate_i;
    new_item.seed    = tag_t'(seed_tag_i);
    new_item.mem_idx = addr_sum[SUM_W-1:3];
  end

  // transfer in when there is room and the tag store is not being cleared
  assign in_stall_o = ctl_i.clearing || (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = ctl_i.pop && (count_q != '0);

  // queue pointers
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= new_item;
    end
  end

  assign head_o.valid = (count_q != '0);
  assign head_o.item  = queue_q[rd_ptr_q];

endmodule

>>> hdl/stt_back.sv
module stt_back import stt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  head_t       head_i,
  output back_ctl_t   ctl_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        trace_valid_o,
  output logic [3:0]  trace_instr_o,
  output logic [15:0] trace_symbol_o,
  output logic [63:0] trace_snapshot_o,
  output logic        trace_side_o,
  output logic        both_symbolic_error_o
);

  // tag stores
  tag_t mem_tags [MEM_WORDS];
  tag_t reg_tags [NUM_REGS];

  state_e            state_q, state_d;
  mem_idx_t          clr_q, clr_d;
  logic [NUM_REGS-1:0] reg_vld_q;

  // registered read data
  tag_t mem_rdata_q;
  tag_t rt1_q, rt2_q;
  logic rv1_q, rv2_q;

  // write ports
  logic     mem_we;
  mem_idx_t mem_waddr;
  tag_t     mem_wdata;
  logic     reg_we;
  tag_t     reg_wdata;
  logic     rd_en;

  // result being formed
  logic        res_trace;
  logic [15:0] res_symbol;
  logic [63:0] res_snapshot;
  logic        res_side;
  logic        res_err;

  // output register
  logic        out_valid_q, out_valid_d;
  logic        trace_valid_q;
  logic [3:0]  trace_instr_q;
  logic [15:0] trace_symbol_q;
  logic [63:0] trace_snapshot_q;
  logic        trace_side_q;
  logic        err_q;

  logic  out_free;
  logic  finish;
  item_t it;
  tag_t  t1, t2;
  logic  is_branch;

  assign it       = head_i.item;
  assign out_free = !out_valid_q || !out_stall_i;
  assign t1       = rv1_q ? rt1_q : '0;
  assign t2       = rv2_q ? rt2_q : '0;

  // sequencer: clearing sweep, read, then execute and retire
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    rd_en   = 1'b0;
    finish  = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (head_i.valid) begin
          rd_en   = 1'b1;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          finish  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  assign ctl_o.pop      = finish;
  assign ctl_o.clearing = (state_q == ST_CLEAR);

  // tag propagation for the instruction at the queue head
  always_comb begin
    reg_we       = 1'b0;
    reg_wdata    = '0;
    mem_we       = 1'b0;
    mem_wdata    = '0;
    res_trace    = 1'b0;
    res_symbol   = '0;
    res_snapshot = '0;
    res_side     = 1'b0;
    res_err      = 1'b0;
    is_branch    = (it.cls == CLS_BRANCH);
    case (it.cls)
      CLS_ADDI: begin
        reg_we    = 1'b1;
        reg_wdata = t1;
        if (t1 != '0) begin
          res_trace    = 1'b1;
          res_symbol   = 16'(t1);
          res_snapshot = 64'($signed(it.imm));
        end
      end
      CLS_LOAD: begin
        reg_we    = 1'b1;
        reg_wdata = mem_rdata_q;
      end
      CLS_STORE: begin
        mem_we    = 1'b1;
        mem_wdata = t2;
      end
      CLS_ALU, CLS_BRANCH: begin
        if ((t1 != '0) && (t2 != '0)) begin
          res_err = 1'b1;
        end else if ((t1 == '0) && (t2 == '0)) begin
          reg_we = !is_branch;
        end else if (t1 == '0) begin
          reg_we       = !is_branch;
          reg_wdata    = t2;
          res_trace    = 1'b1;
          res_symbol   = 16'(t2);
          res_snapshot = it.v1;
          res_side     = 1'b1;
        end else begin
          reg_we       = !is_branch;
          reg_wdata    = t1;
          res_trace    = 1'b1;
          res_symbol   = 16'(t1);
          res_snapshot = it.v2;
        end
      end
      CLS_CONCRETE: begin
        reg_we = 1'b1;
      end
      CLS_SETTAG: begin
        reg_we    = 1'b1;
        reg_wdata = it.seed;
      end
      default: begin
        reg_we = 1'b0;
      end
    endcase
  end

  // memory tag store: clearing sweep or store instruction, one read port
  assign mem_waddr = (state_q == ST_CLEAR) ? clr_q : it.mem_idx;

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_CLEAR) || (finish && mem_we)) begin
      mem_tags[mem_waddr] <= (state_q == ST_CLEAR) ? '0 : mem_wdata;
    end
    if (rd_en) begin
      mem_rdata_q <= mem_tags[it.mem_idx];
    end
  end

  // register tag store: two read ports, one write port
  always_ff @(posedge clk_i) begin
    if (finish && reg_we && (it.rd != '0)) begin
      reg_tags[it.rd] <= reg_wdata;
    end
    if (rd_en) begin
      rt1_q <= reg_tags[it.rs1];
      rt2_q <= reg_tags[it.rs2];
    end
  end

  // written flags for the register tags, register zero never set
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_vld_q <= '0;
      rv1_q     <= 1'b0;
      rv2_q     <= 1'b0;
    end else begin
      if (finish && reg_we && (it.rd != '0)) begin
        reg_vld_q[it.rd] <= 1'b1;
      end
      if (rd_en) begin
        rv1_q <= reg_vld_q[it.rs1];
        rv2_q <= reg_vld_q[it.rs2];
      end
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (finish) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      trace_valid_q    <= res_trace;
      trace_instr_q    <= res_trace ? it.func : 4'd0;
      trace_symbol_q   <= res_symbol;
      trace_snapshot_q <= res_snapshot;
      trace_side_q     <= res_side;
      err_q            <= res_err;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign trace_valid_o         = trace_valid_q;
  assign trace_instr_o         = trace_instr_q;
  assign trace_symbol_o        = trace_symbol_q;
  assign trace_snapshot_o      = trace_snapshot_q;
  assign trace_side_o          = trace_side_q;
  assign both_symbolic_error_o = err_q;

endmodule

>>> hdl/symbolic_tag_tracker_core.sv
// Symbolic tag tracker: follows symbolic tags through a stream of decoded
// instructions, one tag per register and per memory doubleword.
// Input channel: one decoded instruction per transfer (in_valid_i, in_stall_o).
// Output channel: exactly one result per instruction, in order
// (out_valid_o, out_stall_i), carrying a trace record or the error flag.
// Flow: an instruction entering an empty block passes from the queue to the
// tag read, then to execute into the output register.
// The back end takes one instruction at a time: the registered read of
// the tag stores, then the tag write as the instruction retires.
// A two-entry queue separates the input side from the tag stores, so input
// transfers continue while a result waits in the output register.
// Reset: register tags read as concrete at once, as their written flags clear;
// the memory tag store is then cleared by a sweep over all 65536 entries,
// one entry per cycle, and in_stall_o stays high for the whole sweep.
// Receiver stall: the result holds in the output register, the back end
// stops, and once the queue fills in_stall_o rises.
module symbolic_tag_tracker_core import stt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  func_i,
  input  logic [4:0]  dest_reg_i,
  input  logic [4:0]  src1_reg_i,
  input  logic [4:0]  src2_reg_i,
  input  logic [63:0] src1_value_i,
  input  logic [63:0] src2_value_i,
  input  logic [11:0] immediate_i,
  input  logic [15:0] seed_tag_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        trace_valid_o,
  output logic [3:0]  trace_instr_o,
  output logic [15:0] trace_symbol_o,
  output logic [63:0] trace_snapshot_o,
  output logic        trace_side_o,
  output logic        both_symbolic_error_o
);

  head_t     head;
  back_ctl_t ctl;

  // accept and classify
  stt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .dest_reg_i   (dest_reg_i),
    .src1_reg_i   (src1_reg_i),
    .src2_reg_i   (src2_reg_i),
    .src1_value_i (src1_value_i),
    .src2_value_i (src2_value_i),
    .immediate_i  (immediate_i),
    .seed_tag_i   (seed_tag_i),
    .ctl_i        (ctl),
    .head_o       (head)
  );

  // tag stores and result
  stt_back u_back (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .head_i                (head),
    .ctl_o                 (ctl),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .trace_valid_o         (trace_valid_o),
    .trace_instr_o         (trace_instr_o),
    .trace_symbol_o        (trace_symbol_o),
    .trace_snapshot_o      (trace_snapshot_o),
    .trace_side_o          (trace_side_o),
    .both_symbolic_error_o (both_symbolic_error_o)
  );

endmodule

>>> hdl/stt_checker.sv
module stt_checker import stt_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        trace_valid_o,
  input logic [3:0]  trace_instr_o,
  input logic [15:0] trace_symbol_o,
  input logic [63:0] trace_snapshot_o,
  input logic        trace_side_o,
  input logic        both_symbolic_error_o
);

  // a result never carries both a trace and the error flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(trace_valid_o && both_symbolic_error_o))
    else $error("trace and both-symbolic error together");

  // a trace names a symbolic tag and an instruction that can trace
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && trace_valid_o) |-> ((trace_symbol_o != 16'd0) &&
      (trace_instr_o == FN_ADDI || trace_instr_o == FN_ADD || trace_instr_o == FN_SUB ||
       trace_instr_o == FN_MUL || trace_instr_o == FN_DIVU || trace_instr_o == FN_REMU ||
       trace_instr_o == FN_SLTU || trace_instr_o == FN_BEQ)))
    else $error("trace record with concrete tag or non-tracing instruction");

  // without a trace the record fields are zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !trace_valid_o) |-> ((trace_instr_o == 4'd0) &&
      (trace_symbol_o == 16'd0) && (trace_snapshot_o == 64'd0) && !trace_side_o))
    else $error("record fields not cleared without a trace");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(trace_valid_o) &&
      $stable(trace_symbol_o) && $stable(trace_snapshot_o) &&
      $stable(both_symbolic_error_o)))
    else $error("stalled result changed");

endmodule

bind symbolic_tag_tracker_core stt_checker u_stt_checker (.*);

>>> sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import stt_pkg::*;

  // run sizing
  localparam int unsigned RANDOM_ITEMS = 1030;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned LIMIT_CYCLES = 400000;

  // function code with no meaning in the decoder
  localparam logic [3:0]  FN_RESERVED = 4'd15;
  localparam logic [63:0] ONES        = 64'hFFFF_FFFF_FFFF_FFFF;

  // one decoded instruction
  typedef struct packed {
    logic [3:0]  func;
    logic [4:0]  dest_reg;
    logic [4:0]  src1_reg;
    logic [4:0]  src2_reg;
    logic [63:0] src1_value;
    logic [63:0] src2_value;
    logic [11:0] immediate;
    logic [15:0] seed_tag;
  } instr_t;

  // one result record
  typedef struct packed {
    logic        trace_valid;
    logic [3:0]  trace_instr;
    logic [15:0] trace_symbol;
    logic [63:0] trace_snapshot;
    logic        trace_side;
    logic        both_symbolic_error;
  } result_t;

  typedef struct packed {
    instr_t  ins;
    logic    typed;
    result_t want;
  } row_t;

  localparam result_t RES_NONE = '0;
  localparam result_t ERR_BOTH = '{both_symbolic_error: 1'b1, default: '0};

  // directed opening: extremes, every function code, the special cases
  localparam row_t DIRECTED [25] = '{
    // after reset everything is concrete
    '{'{FN_ADDI, 5'd1, 5'd0, 5'd0, 64'd0, 64'd0, 12'h000, 16'h0000}, 1'b1, RES_NONE},
    '{'{FN_LD, 5'd2, 5'd0, 5'd0, 64'd0, 64'd0, 12'h000, 16'h0000}, 1'b1, RES_NONE},
    // register zero ignores a seed
    '{'{FN_SETTAG, 5'd0, 5'd0, 5'd0, 64'd0, 64'd0, 12'h000, 16'hFFFF}, 1'b1, RES_NONE},
    '{'{FN_SETTAG, 5'd31, 5'd0, 5'd0, 64'd0, 64'd0, 12'h000, 16'hFFFF}, 1'b1, RES_NONE},
    // immediate extremes show up sign-extended
    '{'{FN_ADDI, 5'd5, 5'd31, 5'd0, 64'd0, 64'd0, 12'h800, 16'h0000}, 1'b1,
      '{1'b1, FN_ADDI, 16'hFFFF, 64'hFFFF_FFFF_FFFF_F800, 1'b0, 1'b0}},
    '{'{FN_ADDI, 5'd6, 5'd31, 5'd0, ONES, ONES, 12'h7FF, 16'h0000}, 1'b1,
      '{1'b1, FN_ADDI, 16'hFFFF, 64'h0000_0000_0000_07FF, 1'b0, 1'b0}},
    '{'{FN_SETTAG, 5'd1, 5'd0, 5'd0, 64'd0, 64'd0, 12'h000, 16'h0001}, 1'b1, RES_NONE},
    // both operands symbolic
    '{'{FN_ADD, 5'd2, 5'd31, 5'd1, ONES, ONES, 12'h000, 16'h0000}, 1'b1, ERR_BOTH},
    // branch with symbolic right operand
    '{'{FN_BEQ, 5'd3, 5'd0, 5'd1, ONES, 64'd0, 12'h000, 16'h0000}, 1'b1,
      '{1'b1, FN_BEQ, 16'h0001, ONES, 1'b1, 1'b0}},
    '{'{FN_SUB, 5'd7, 5'd1, 5'd0, ONES, 64'd0, 12'h000, 16'h0000}, 1'b1,
      '{1'b1, FN_SUB, 16'h0001, 64'd0, 1'b0, 1'b0}},
    '{'{FN_MUL, 5'd8, 5'd0, 5'd31, 64'h8000_0000_0000_0000, ONES, 12'h000, 16'h0000}, 1'b1,
      '{1'b1, FN_MUL, 16'hFFFF, 64'h8000_0000_0000_0000, 1'b1, 1'b0}},
    '{'{FN_DIVU, 5'd9, 5'd5, 5'd3, ONES, 64'd1, 12'h000, 16'h0000}, 1'b0, RES_NONE},
    '{'{FN_REMU, 5'd10, 5'd3, 5'd6, 64'h0123_4567_89AB_CDEF, 64'd0, 12'h000, 16'h0000},
      1'b0, RES_NONE},
    '{'{FN_SLTU, 5'd11, 5'd6, 5'd7, 64'd5, 64'd9, 12'h000, 16'h0000}, 1'b0, RES_NONE},
    // address sum wraps past the top of the 64-bit space
    '{'{FN_SD, 5'd0, 5'd0, 5'd31, ONES, 64'd0, 12'h7FF, 16'h0000}, 1'b0, RES_NONE},
    '{'{FN_LD, 5'd12, 5'd0, 5'd0, ONES, 64'd0, 12'h7FF, 16'h0000}, 1'b0, RES_NONE},
    '{'{FN_ADDI, 5'd13, 5'd12, 5'd0, 64'd0, 64'd0, 12'h000, 16'h0000}, 1'b0, RES_NONE},
    // negative offset from zero lands on the last doubleword
    '{'{FN_SD, 5'd0, 5'd0, 5'd1, 64'd0, 64'd0, 12'hFF8, 16'h0000}, 1'b0, RES_NONE},
    '{'{FN_LD, 5'd14, 5'd0, 5'd0, 64'h7FFF8, 64'd0, 12'h000, 16'h0000}, 1'b0, RES_NONE},
    // jumps and lui make rd concrete
    '{'{FN_JAL, 5'd31, 5'd0, 5'd0, 64'd0, 64'd0, 12'h000, 16'h0000}, 1'b1, RES_NONE},
    '{'{FN_JALR, 5'd5, 5'd1, 5'd0, 64'd0, 64'd0, 12'h000, 16'h0000}, 1'b1, RES_NONE},
    '{'{FN_LUI, 5'd6, 5'd0, 5'd0, 64'd0, 64'd0, 12'h000, 16'h0000}, 1'b1, RES_NONE},
    '{'{FN_ADDI, 5'd16, 5'd31, 5'd0, 64'd0, 64'd0, 12'h000, 16'h0000}, 1'b1, RES_NONE},
    // codes that do nothing
    '{'{FN_OTHER, 5'd17, 5'd14, 5'd1, ONES, ONES, 12'hFFF, 16'hFFFF}, 1'b1, RES_NONE},
    '{'{FN_RESERVED, 5'd18, 5'd14, 5'd1, ONES, ONES, 12'hFFF, 16'hFFFF}, 1'b1, RES_NONE}
  };

  // memory bases that make loads meet earlier stores
  localparam logic [63:0] ADDR_BASES [4] = '{
    64'h0, 64'h1000, 64'hFFFF_FFFF_FFFF_FFF8, 64'h0000_0000_0007_FFF8
  };

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_stall_o;
  logic [3:0]  func_i       = '0;
  logic [4:0]  dest_reg_i   = '0;
  logic [4:0]  src1_reg_i   = '0;
  logic [4:0]  src2_reg_i   = '0;
  logic [63:0] src1_value_i = '0;
  logic [63:0] src2_value_i = '0;
  logic [11:0] immediate_i  = '0;
  logic [15:0] seed_tag_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i  = 1'b0;
  logic        trace_valid_o;
  logic [3:0]  trace_instr_o;
  logic [15:0] trace_symbol_o;
  logic [63:0] trace_snapshot_o;
  logic        trace_side_o;
  logic        both_symbolic_error_o;

  // shadow tag stores
  tag_t reg_tags [NUM_REGS]  = '{default: '0};
  tag_t mem_tags [MEM_WORDS] = '{default: '0};

  result_t     results_due [$];
  int unsigned instrs_sent     = 0;
  int unsigned results_checked = 0;
  int unsigned traces_seen     = 0;
  int unsigned flags_seen      = 0;
  int unsigned mismatches      = 0;
  int unsigned cycle_count     = 0;
  logic        no_idle         = 1'b0;
  logic        long_hold_done  = 1'b0;

  symbolic_tag_tracker_core dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .func_i                (func_i),
    .dest_reg_i            (dest_reg_i),
    .src1_reg_i            (src1_reg_i),
    .src2_reg_i            (src2_reg_i),
    .src1_value_i          (src1_value_i),
    .src2_value_i          (src2_value_i),
    .immediate_i           (immediate_i),
    .seed_tag_i            (seed_tag_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .trace_valid_o         (trace_valid_o),
    .trace_instr_o         (trace_instr_o),
    .trace_symbol_o        (trace_symbol_o),
    .trace_snapshot_o      (trace_snapshot_o),
    .trace_side_o          (trace_side_o),
    .both_symbolic_error_o (both_symbolic_error_o)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // register zero always stays concrete
  function automatic void put_reg_tag(input logic [4:0] r, input tag_t t);
    if (r != '0) reg_tags[r] = t;
  endfunction

  function automatic result_t traced(input logic [3:0] fn, input tag_t sym,
                                     input logic [63:0] snap, input logic side);
    result_t r;
    r = '0;
    r.trace_valid    = 1'b1;
    r.trace_instr    = fn;
    r.trace_symbol   = sym;
    r.trace_snapshot = snap;
    r.trace_side     = side;
    return r;
  endfunction

  // tag propagation for one instruction, updates the shadow stores
  function automatic result_t track_tags(input instr_t ins);
    result_t     res;
    tag_t        t1;
    tag_t        t2;
    logic [63:0] imm64;
    logic [63:0] addr;
    mem_idx_t    widx;
    res   = '0;
    t1    = reg_tags[ins.src1_reg];
    t2    = reg_tags[ins.src2_reg];
    imm64 = {{52{ins.immediate[11]}}, ins.immediate};
    addr  = ins.src1_value + imm64;
    widx  = addr[MEM_AW+2:3];
    case (ins.func)
      FN_ADDI: begin
        put_reg_tag(ins.dest_reg, t1);
        if (t1 != '0) res = traced(FN_ADDI, t1, imm64, 1'b0);
      end
      FN_LD: put_reg_tag(ins.dest_reg, mem_tags[widx]);
      FN_SD: mem_tags[widx] = t2;
      FN_ADD, FN_SUB, FN_MUL, FN_DIVU, FN_REMU, FN_SLTU, FN_BEQ: begin
        if (t1 != '0 && t2 != '0) begin
          res.both_symbolic_error = 1'b1;
        end else begin
          // at most one side is symbolic here, so the or picks it
          if (ins.func != FN_BEQ) put_reg_tag(ins.dest_reg, t1 | t2);
          if (t2 != '0) res = traced(ins.func, t2, ins.src1_value, 1'b1);
          else if (t1 != '0) res = traced(ins.func, t1, ins.src2_value, 1'b0);
        end
      end
      FN_JAL, FN_JALR, FN_LUI: put_reg_tag(ins.dest_reg, '0);
      FN_SETTAG: put_reg_tag(ins.dest_reg, ins.seed_tag);
      default: ;
    endcase
    return res;
  endfunction

  // registers lean towards a small set so tags meet often
  function automatic logic [4:0] pick_reg();
    if ($urandom_range(0, 1) == 0) return 5'($urandom_range(0, 7));
    return 5'($urandom_range(0, 31));
  endfunction

  function automatic instr_t random_instr();
    instr_t      ins;
    int unsigned pick;
    int unsigned seed_pick;
    pick           = $urandom_range(0, 99);
    seed_pick      = $urandom_range(0, 9);
    ins.dest_reg   = pick_reg();
    ins.src1_reg   = pick_reg();
    ins.src2_reg   = pick_reg();
    ins.src1_value = {$urandom, $urandom};
    ins.src2_value = {$urandom, $urandom};
    ins.immediate  = 12'($urandom);
    if (seed_pick == 0) ins.seed_tag = '0;
    else if (seed_pick == 1) ins.seed_tag = '1;
    else ins.seed_tag = 16'($urandom);
    if (pick < 20) ins.func = FN_ADDI;
    else if (pick < 32) ins.func = FN_LD;
    else if (pick < 44) ins.func = FN_SD;
    else if (pick < 68) ins.func = FN_ADD + 4'($urandom_range(0, 5));
    else if (pick < 76) ins.func = FN_BEQ;
    else if (pick < 85) ins.func = FN_JAL + 4'($urandom_range(0, 2));
    else if (pick < 97) ins.func = FN_SETTAG;
    else ins.func = ($urandom_range(0, 1) == 0) ? FN_OTHER : FN_RESERVED;
    // most memory accesses hit a few shared doublewords
    if ((ins.func == FN_LD || ins.func == FN_SD) && $urandom_range(0, 3) != 0) begin
      ins.src1_value = ADDR_BASES[$urandom_range(0, 3)];
      ins.immediate  = 12'($urandom_range(0, 8) * 8) - 12'd32;
    end
    return ins;
  endfunction

  // offer one instruction until it transfers, then predict its result
  task automatic send_instr(input instr_t ins, input logic typed, input result_t want);
    result_t predicted;
    logic    taken;
    while (!no_idle && $urandom_range(0, 99) < 29) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    func_i       <= ins.func;
    dest_reg_i   <= ins.dest_reg;
    src1_reg_i   <= ins.src1_reg;
    src2_reg_i   <= ins.src2_reg;
    src1_value_i <= ins.src1_value;
    src2_value_i <= ins.src2_value;
    immediate_i  <= ins.immediate;
    seed_tag_i   <= ins.seed_tag;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = (in_stall_o === 1'b0);
      @(posedge clk_i);
    end
    predicted = track_tags(ins);
    results_due.push_back(typed ? want : predicted);
    instrs_sent++;
  endtask

  // stimulus
  initial begin : stimulus
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (DIRECTED[i]) send_instr(DIRECTED[i].ins, DIRECTED[i].typed, DIRECTED[i].want);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      no_idle = (n >= 400 && n < 550);
      // let the block drain completely once
      if (n == 600) begin
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (results_due.size() != 0);
      end
      send_instr(random_instr(), 1'b0, RES_NONE);
    end
    in_valid_i <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("summary: %0d instructions, %0d results, %0d traces, %0d both-symbolic flags",
             instrs_sent, results_checked, traces_seen, flags_seen);
    $display("summary: includes reset sweep, long output hold-off and a full drain pause");
    if (mismatches == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

  // receiver stall, with one long hold-off so the queue fills
  initial begin : result_sink
    forever begin
      @(posedge clk_i);
      if (!long_hold_done && results_checked >= 150) begin
        long_hold_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_stall_i <= !no_idle && ($urandom_range(0, 99) < 29);
    end
  end

  // compare each output transfer with the oldest prediction
  always @(negedge clk_i) begin : check_results
    result_t want;
    if (out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (results_due.size() == 0) begin
        $error("result transfer with nothing outstanding");
        mismatches++;
      end else begin
        want = results_due.pop_front();
        results_checked++;
        if (want.trace_valid) traces_seen++;
        if (want.both_symbolic_error) flags_seen++;
        if (trace_valid_o !== want.trace_valid) begin
          $error("trace_valid: expected %0h, got %0h", want.trace_valid, trace_valid_o);
          mismatches++;
        end
        if (trace_instr_o !== want.trace_instr) begin
          $error("trace_instr: expected %0h, got %0h", want.trace_instr, trace_instr_o);
          mismatches++;
        end
        if (trace_symbol_o !== want.trace_symbol) begin
          $error("trace_symbol: expected %h, got %h", want.trace_symbol, trace_symbol_o);
          mismatches++;
        end
        if (trace_snapshot_o !== want.trace_snapshot) begin
          $error("trace_snapshot: expected %h, got %h", want.trace_snapshot,
                 trace_snapshot_o);
          mismatches++;
        end
        if (trace_side_o !== want.trace_side) begin
          $error("trace_side: expected %0h, got %0h", want.trace_side, trace_side_o);
          mismatches++;
        end
        if (both_symbolic_error_o !== want.both_symbolic_error) begin
          $error("both_symbolic_error: expected %0h, got %0h", want.both_symbolic_error,
                 both_symbolic_error_o);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

endmodule

>>> files.f
hdl/stt_pkg.sv
hdl/stt_front.sv
hdl/stt_back.sv
hdl/symbolic_tag_tracker_core.sv
hdl/stt_checker.sv
sim/testbench.sv
